[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the prefix trie engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is high.
`define PTE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be true.
`define PTE_NEVER(label, expr, msg) \
   `PTE_ASSERT(label, !(expr), msg)

`endif

[rtl/core/pte_pkg.sv]
// Package of the prefix trie engine: sizes, opcodes, payload and control types.
package pte_pkg;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int TABLE_SIZE    = NODE_COUNT * ALPHABET_SIZE;
   localparam int NODE_W        = $clog2(NODE_COUNT);
   localparam int USED_W        = $clog2(NODE_COUNT + 1);
   localparam int SLOT_W        = $clog2(TABLE_SIZE);
   localparam int LETTER_W      = 5;
   localparam int OPCODE_W      = 2;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PREFIX = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NONE   = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [LETTER_W-1:0] letter;
      logic                last_letter;
   } trie_req_type;

   typedef struct packed {
      logic found;
      logic status;
   } trie_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_FINISH,
      ST_CHECK
   } pte_state_type;

   typedef struct packed {
      logic clear_write;
      logic capture;
      logic resolve;
      logic mark_end;
      logic read_end;
      logic respond;
   } pte_cmd_type;

   typedef struct packed {
      logic                clear_last;
      logic [OPCODE_W-1:0] opcode;
      logic                last_letter;
   } pte_stat_type;

endpackage

[rtl/core/pte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pte_ctrl.sv]
// Controller state machine of the prefix trie engine.
module pte_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  pte_pkg::pte_stat_type stat,
   output pte_pkg::pte_cmd_type  cmd,
   output logic                  busy
);

   pte_pkg::pte_state_type state_ff;
   pte_pkg::pte_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pte_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pte_pkg::ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = pte_pkg::ST_IDLE;
            end
         end
         pte_pkg::ST_IDLE: begin
            if (start) begin
               state_in = pte_pkg::ST_LOOKUP;
            end
         end
         pte_pkg::ST_LOOKUP: begin
            if (stat.opcode == pte_pkg::OP_NONE || !stat.last_letter) begin
               state_in = pte_pkg::ST_IDLE;
            end else begin
               state_in = pte_pkg::ST_FINISH;
            end
         end
         pte_pkg::ST_FINISH: begin
            if (stat.opcode == pte_pkg::OP_SEARCH) begin
               state_in = pte_pkg::ST_CHECK;
            end else begin
               state_in = pte_pkg::ST_IDLE;
            end
         end
         pte_pkg::ST_CHECK: begin
            state_in = pte_pkg::ST_IDLE;
         end
         default: begin
            state_in = pte_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         pte_pkg::ST_CLEAR: begin
            cmd.clear_write = 1'b1;
         end
         pte_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         pte_pkg::ST_LOOKUP: begin
            cmd.resolve = 1'b1;
         end
         pte_pkg::ST_FINISH: begin
            if (stat.opcode == pte_pkg::OP_SEARCH) begin
               cmd.read_end = 1'b1;
            end else begin
               cmd.mark_end = (stat.opcode == pte_pkg::OP_INSERT);
               cmd.respond  = 1'b1;
            end
         end
         pte_pkg::ST_CHECK: begin
            cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/core/pte_datapath.sv]
// Datapath of the prefix trie engine: walk registers, node pool and child table.
module pte_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  pte_pkg::trie_req_type req_data,
   input  pte_pkg::pte_cmd_type  cmd,
   output pte_pkg::pte_stat_type stat,
   output logic                  rsp_strobe,
   output pte_pkg::trie_rsp_type rsp_data
);

   logic [pte_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic [pte_pkg::LETTER_W-1:0] letter_ff, letter_in;
   logic                         last_ff, last_in;
   logic [pte_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [pte_pkg::NODE_W-1:0]   cursor_ff, cursor_in;
   logic [pte_pkg::USED_W-1:0]   nodes_used_ff, nodes_used_in;
   logic                         miss_ff, miss_in;
   logic                         full_ff, full_in;
   logic [pte_pkg::SLOT_W-1:0]   clear_cnt_ff, clear_cnt_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   pte_pkg::trie_rsp_type        rsp_ff, rsp_in;

   logic                         req_letter_bad;
   logic                         walk_ok;
   logic                         alloc;
   logic [pte_pkg::NODE_W-1:0]   new_node;
   logic                         child_wr_en;
   logic [pte_pkg::SLOT_W-1:0]   child_wr_addr;
   logic [pte_pkg::NODE_W-1:0]   child_wr_data;
   logic [pte_pkg::NODE_W-1:0]   child_rd_data;
   logic                         end_wr_en;
   logic [pte_pkg::NODE_W-1:0]   end_wr_addr;
   logic                         end_wr_data;
   logic                         end_rd_data;

   assign req_letter_bad = req_data.letter >= pte_pkg::LETTER_W'(pte_pkg::ALPHABET_SIZE);
   assign slot_in = pte_pkg::SLOT_W'(cursor_ff) * pte_pkg::SLOT_W'(pte_pkg::ALPHABET_SIZE)
                  + pte_pkg::SLOT_W'(req_data.letter);
   assign walk_ok  = !miss_ff && !full_ff;
   assign new_node = nodes_used_ff[pte_pkg::NODE_W-1:0];

   always_comb begin
      op_in         = op_ff;
      letter_in     = letter_ff;
      last_in       = last_ff;
      cursor_in     = cursor_ff;
      nodes_used_in = nodes_used_ff;
      miss_in       = miss_ff;
      full_in       = full_ff;
      clear_cnt_in  = clear_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      alloc         = 1'b0;

      if (cmd.clear_write) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
      end

      if (cmd.capture) begin
         op_in     = req_data.opcode;
         letter_in = req_data.letter;
         last_in   = req_data.last_letter;
      end

      if (cmd.resolve && op_ff != pte_pkg::OP_NONE && walk_ok) begin
         if (letter_ff >= pte_pkg::LETTER_W'(pte_pkg::ALPHABET_SIZE)) begin
            miss_in = 1'b1;
         end else if (child_rd_data != '0) begin
            cursor_in = child_rd_data;
         end else if (op_ff != pte_pkg::OP_INSERT) begin
            miss_in = 1'b1;
         end else if (nodes_used_ff >= pte_pkg::USED_W'(pte_pkg::NODE_COUNT)) begin
            full_in = 1'b1;
         end else begin
            alloc         = 1'b1;
            cursor_in     = new_node;
            nodes_used_in = nodes_used_ff + 1'b1;
         end
      end

      if (cmd.respond) begin
         rsp_strobe_in = 1'b1;
         case (op_ff)
            pte_pkg::OP_INSERT: begin
               rsp_in.found  = walk_ok;
               rsp_in.status = full_ff;
            end
            pte_pkg::OP_SEARCH: begin
               rsp_in.found  = walk_ok && end_rd_data;
               rsp_in.status = 1'b0;
            end
            default: begin
               rsp_in.found  = walk_ok;
               rsp_in.status = 1'b0;
            end
         endcase
         cursor_in = '0;
         miss_in   = 1'b0;
         full_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= '0;
         nodes_used_ff <= pte_pkg::USED_W'(1);
         miss_ff       <= 1'b0;
         full_ff       <= 1'b0;
         clear_cnt_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cursor_ff     <= cursor_in;
         nodes_used_ff <= nodes_used_in;
         miss_ff       <= miss_in;
         full_ff       <= full_in;
         clear_cnt_ff  <= clear_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
      rsp_ff    <= rsp_in;
      if (cmd.capture) begin
         slot_ff <= slot_in;
      end
   end

   // child pointers; swept to zero after reset
   always_comb begin
      if (cmd.clear_write) begin
         child_wr_en   = 1'b1;
         child_wr_addr = clear_cnt_ff;
         child_wr_data = '0;
      end else begin
         child_wr_en   = alloc;
         child_wr_addr = slot_ff;
         child_wr_data = new_node;
      end
   end

   pte_ram #(
      .WIDTH (pte_pkg::NODE_W),
      .DEPTH (pte_pkg::TABLE_SIZE)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (child_wr_addr),
      .wr_data (child_wr_data),
      .rd_en   (cmd.capture && !req_letter_bad),
      .rd_addr (slot_in),
      .rd_data (child_rd_data)
   );

   // end-of-word marks; cleared when a node is allocated
   assign end_wr_en   = alloc || (cmd.mark_end && walk_ok);
   assign end_wr_addr = alloc ? new_node : cursor_ff;
   assign end_wr_data = !alloc;

   pte_ram #(
      .WIDTH (1),
      .DEPTH (pte_pkg::NODE_COUNT)
   ) u_end_ram (
      .clock   (clock),
      .wr_en   (end_wr_en),
      .wr_addr (end_wr_addr),
      .wr_data (end_wr_data),
      .rd_en   (cmd.read_end),
      .rd_addr (cursor_ff),
      .rd_data (end_rd_data)
   );

   assign stat.clear_last  = (clear_cnt_ff == pte_pkg::SLOT_W'(pte_pkg::TABLE_SIZE - 1));
   assign stat.opcode      = op_ff;
   assign stat.last_letter = last_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[rtl/core/prefix_trie_engine.sv]
// Top level of the prefix trie engine: 26-letter trie with insert, exact search and prefix search.
//
// Words arrive one letter per transaction on req_data (opcode, letter,
// last_letter); a transaction is taken at a rising edge with start high and
// busy low. Opcode 3 is ignored and gives no result.
// A letter that is not last passes through the accept cycle, which reads the
// child table, and a lookup cycle that follows or allocates the child. No new
// letter is taken until the child-table read and any allocation write are done.
// A last letter of an insert or prefix search then adds a finish step; an exact
// search also adds a check step, for the extra end-of-word mark read.
// The single result (found, status) appears on rsp_data for one cycle with
// rsp_strobe high, in the cycle after the last busy cycle of the word's final
// letter. The receiver cannot stall; a result is shown exactly once.
// After reset the child table is cleared one entry a cycle, all 26624 entries,
// while busy stays high; the walk returns to the root and the pool holds
// only the root.
`include "assert_macros.svh"

module prefix_trie_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pte_pkg::trie_req_type req_data,
   output logic                  rsp_strobe,
   output pte_pkg::trie_rsp_type rsp_data
);

   pte_pkg::pte_cmd_type  cmd;
   pte_pkg::pte_stat_type stat;

   pte_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   pte_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   `PTE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
   `PTE_ASSERT(a_rsp_after_busy, rsp_strobe |-> $past(busy), "result without a busy cycle before")
   `PTE_ASSERT(a_rsp_single, rsp_strobe |=> !rsp_strobe, "result strobe held two cycles")
   `PTE_NEVER(a_cmd_overlap, cmd.capture && (cmd.respond || cmd.clear_write), "capture overlaps")

endmodule

[test/prefix_trie_engine_checker.sv]
// Checker for the prefix trie engine: trie predictor and result comparison.
`timescale 1ns / 100ps

module prefix_trie_engine_checker
   import pte_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  trie_req_type req_data,
   input  logic         rsp_strobe,
   input  trie_rsp_type rsp_data,
   output int           mismatch_count,
   output int           answers_pending
);

   logic [NODE_W-1:0] child_ptr [TABLE_SIZE];
   bit                word_end [NODE_COUNT];
   int                node_total;
   int                cursor;
   bit                walk_missed;
   bit                pool_full;
   trie_rsp_type      answer_q [$];

   // Advances the walk by one letter; returns 1 when the transaction ends a word.
   function automatic bit walk_and_answer(input trie_req_type t, output trie_rsp_type answer);
      int slot;
      int next_node;
      int i;
      bit ok;
      answer = '0;
      if (t.opcode == OP_NONE) return 0;
      if (!walk_missed && !pool_full) begin
         if (t.letter >= ALPHABET_SIZE) begin
            walk_missed = 1;
         end else begin
            slot = cursor * ALPHABET_SIZE + int'(t.letter);
            next_node = int'(child_ptr[slot]);
            if (next_node == 0 && t.opcode != OP_INSERT) begin
               walk_missed = 1;
            end else if (next_node == 0 && node_total >= NODE_COUNT) begin
               pool_full = 1;
            end else begin
               if (next_node == 0) begin
                  next_node = node_total;
                  child_ptr[slot] = NODE_W'(next_node);
                  word_end[next_node] = 0;
                  for (i = 0; i < ALPHABET_SIZE; i++)
                     child_ptr[next_node * ALPHABET_SIZE + i] = '0;
                  node_total++;
               end
               cursor = next_node;
            end
         end
      end
      if (!t.last_letter) return 0;
      ok = !walk_missed && !pool_full;
      case (t.opcode)
         OP_INSERT: begin
            if (ok) word_end[cursor] = 1;
            answer.found  = ok;
            answer.status = pool_full;
         end
         OP_SEARCH: answer.found = ok && word_end[cursor];
         default:   answer.found = ok;
      endcase
      cursor      = 0;
      walk_missed = 0;
      pool_full   = 0;
      return 1;
   endfunction

   always @(posedge clock) begin
      trie_rsp_type predicted;
      trie_rsp_type oldest;
      int i;
      if (reset) begin
         for (i = 0; i < TABLE_SIZE; i++) child_ptr[i] = '0;
         for (i = 0; i < NODE_COUNT; i++) word_end[i] = 0;
         node_total     = 1;
         cursor         = 0;
         walk_missed    = 0;
         pool_full      = 0;
         mismatch_count = 0;
         answer_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (answer_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: result with none pending: found=%0b status=%0b",
                           $realtime, rsp_data.found, rsp_data.status);
               mismatch_count++;
            end else begin
               oldest = answer_q.pop_front();
               if (rsp_data.found !== oldest.found || rsp_data.status !== oldest.status) begin
                  if (mismatch_count < 10)
                     $display("%0t: mismatch: expected found=%0b status=%0b, got found=%0b status=%0b",
                              $realtime, oldest.found, oldest.status,
                              rsp_data.found, rsp_data.status);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy && walk_and_answer(req_data, predicted))
            answer_q.push_back(predicted);
      end
      answers_pending <= answer_q.size();
   end

endmodule

[test/prefix_trie_engine_tb.sv]
// Testbench top for the prefix trie engine: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module prefix_trie_engine_tb;
   import pte_pkg::*;

   localparam int IDLE_LIMIT   = 100000;
   localparam int RANDOM_ITEMS = 400;
   localparam int WORD_MAX     = 8;
   localparam int BUF_LEN      = 32;
   localparam int HIST_DEPTH   = 64;
   localparam int FILL_WORDS   = 8;
   localparam int FILL_LEN     = 26;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   trie_req_type req_data = '0;
   logic         busy;
   logic         rsp_strobe;
   trie_rsp_type rsp_data;
   int           mismatch_count;
   int           answers_pending;

   int                  idle_cycles = 0;
   int                  items_sent  = 0;
   int                  quiet_words = 0;
   logic [LETTER_W-1:0] word_buf [BUF_LEN];
   logic [LETTER_W-1:0] hist_word [HIST_DEPTH][WORD_MAX];
   int                  hist_len [HIST_DEPTH];
   int                  hist_count = 0;
   int                  hist_next  = 0;

   always #5 clock = ~clock;

   prefix_trie_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   prefix_trie_engine_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending)
   );

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("prefix_trie_engine_tb: FAIL");
      $finish;
   end

   task automatic pause_after_item();
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (quiet_words > 0 || pick < 55) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [LETTER_W-1:0] letter,
                            input logic last);
      trie_req_type item;
      item.opcode      = op;
      item.letter      = letter;
      item.last_letter = last;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if (op != OP_NONE) items_sent++;
      pause_after_item();
   endtask

   task automatic wait_for_answers();
      start <= 1'b0;
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
   endtask

   task automatic send_word(input logic [OPCODE_W-1:0] op, input int len, input bit mixed,
                            input bit with_skip);
      int i;
      logic [OPCODE_W-1:0] letter_op;
      for (i = 0; i < len; i++) begin
         if (with_skip && i == len / 2)
            send_item(OP_NONE, LETTER_W'($urandom), 1'($urandom));
         letter_op = (mixed && i != len - 1) ? OPCODE_W'($urandom_range(0, 2)) : op;
         send_item(letter_op, word_buf[i], i == len - 1);
      end
      if (quiet_words > 0) quiet_words--;
   endtask

   function automatic logic [LETTER_W-1:0] random_letter();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return LETTER_W'($urandom_range(0, 3));
      if (pick < 97) return LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
      return LETTER_W'($urandom_range(ALPHABET_SIZE, 31));
   endfunction

   task automatic send_random_word();
      int pick;
      int len;
      int src;
      int i;
      logic [OPCODE_W-1:0] op;
      pick = $urandom_range(0, 99);
      op = pick < 40 ? OP_INSERT : (pick < 75 ? OP_SEARCH : OP_PREFIX);
      if (hist_count > 0 && $urandom_range(0, 1) == 1) begin
         src = $urandom_range(0, hist_count - 1);
         len = hist_len[src];
         for (i = 0; i < len; i++) word_buf[i] = hist_word[src][i];
         case ($urandom_range(0, 3))
            0: len = $urandom_range(1, len);
            1: if (len < WORD_MAX) begin
               word_buf[len] = random_letter();
               len++;
            end
            default: ;
         endcase
      end else begin
         len = $urandom_range(1, 6);
         for (i = 0; i < len; i++) word_buf[i] = random_letter();
      end
      if (op == OP_INSERT) begin
         for (i = 0; i < len; i++) hist_word[hist_next][i] = word_buf[i];
         hist_len[hist_next] = len;
         hist_next = (hist_next + 1) % HIST_DEPTH;
         if (hist_count < HIST_DEPTH) hist_count++;
      end
      send_word(op, len, $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0);
      if ($urandom_range(0, 39) == 0) wait_for_answers();
      if ($urandom_range(0, 29) == 0) quiet_words = $urandom_range(5, 20);
   endtask

   initial begin
      int w;
      int i;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_INSERT, 5'd0, 1'b1);
      send_item(OP_SEARCH, 5'd0, 1'b1);
      send_item(OP_INSERT, 5'd25, 1'b0);
      send_item(OP_INSERT, 5'd25, 1'b1);
      send_item(OP_PREFIX, 5'd25, 1'b1);
      send_item(OP_SEARCH, 5'd25, 1'b1);
      send_item(OP_SEARCH, 5'd25, 1'b0);
      send_item(OP_SEARCH, 5'd25, 1'b1);
      // letters past z, then opcode-3 items alone and inside a word
      send_item(OP_SEARCH, 5'd31, 1'b1);
      send_item(OP_INSERT, 5'd0, 1'b0);
      send_item(OP_INSERT, 5'd26, 1'b1);
      send_item(OP_PREFIX, 5'd30, 1'b1);
      send_item(OP_NONE, 5'd7, 1'b1);
      send_item(OP_INSERT, 5'd1, 1'b0);
      send_item(OP_NONE, 5'd31, 1'b0);
      send_item(OP_INSERT, 5'd2, 1'b1);
      // mixed opcodes, then letters after a miss
      send_item(OP_INSERT, 5'd3, 1'b0);
      send_item(OP_PREFIX, 5'd4, 1'b1);
      send_item(OP_SEARCH, 5'd5, 1'b0);
      send_item(OP_SEARCH, 5'd0, 1'b1);
      send_item(OP_INSERT, 5'd3, 1'b0);
      send_item(OP_SEARCH, 5'd1, 1'b1);
      wait_for_answers();

      while (items_sent < RANDOM_ITEMS) send_random_word();
      wait_for_answers();

      // long unique words deep in the tree
      for (w = 0; w < FILL_WORDS; w++) begin
         for (i = 0; i < FILL_LEN; i++) word_buf[i] = LETTER_W'($urandom_range(0, ALPHABET_SIZE - 1));
         send_word(OP_INSERT, FILL_LEN, 1'b0, 1'b0);
      end

      repeat (25) send_random_word();
      wait_for_answers();
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) $display("prefix_trie_engine_tb: PASS");
      else $display("prefix_trie_engine_tb: FAIL");
      $finish;
   end

endmodule
